### hw/rtl/max_heap_priority_queue_top_defines.svh
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top_defines
// assertion macros used by the heap queue checker
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define MHPQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mhpq assertion failed");

// next-cycle implication, quiet during reset
`define MHPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mhpq assertion failed");

`endif

### hw/rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// types, constants and the control store of the heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CW       = $clog2(CAPACITY + 1);
	localparam int LW       = AW + 1;
	localparam int FILL_W   = 11;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] pay;
	} entry_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_IDLE,
		ACT_INS_INIT,
		ACT_RD_PAR,
		ACT_INS_MOVE,
		ACT_WR_ENT,
		ACT_EX_INIT,
		ACT_EX_ROOT,
		ACT_EX_LAST,
		ACT_DN_LEFT,
		ACT_DN_CMPL,
		ACT_DN_CMPR,
		ACT_FIN
	} act_t;

	typedef enum logic [3:0] {
		C_ALWAYS,
		C_IN_VALID,
		C_OP_EXTRACT,
		C_FULL,
		C_POS_ROOT,
		C_LESS_UP,
		C_CNT_ZERO,
		C_NO_LEFT,
		C_MOVE,
		C_OUT_FREE
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t S_IDLE = 4'd0;
	localparam step_t S_DISP = 4'd1;
	localparam step_t S_I0   = 4'd2;
	localparam step_t S_I1   = 4'd3;
	localparam step_t S_I2   = 4'd4;
	localparam step_t S_WR   = 4'd5;
	localparam step_t S_E0   = 4'd6;
	localparam step_t S_E1   = 4'd7;
	localparam step_t S_E2   = 4'd8;
	localparam step_t S_E3   = 4'd9;
	localparam step_t S_E4   = 4'd10;
	localparam step_t S_E5   = 4'd11;
	localparam step_t S_FIN  = 4'd12;

	// one control word: action, branch condition, target if true, target if false
	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} uword_t;

	function automatic uword_t ucode(input step_t pc);
		uword_t w;
		w = '{act: ACT_NOP, cond: C_ALWAYS, tgt_t: S_IDLE, tgt_f: S_IDLE};
		unique case (pc)
			S_IDLE: w = '{act: ACT_IDLE,     cond: C_IN_VALID,   tgt_t: S_DISP, tgt_f: S_IDLE};
			S_DISP: w = '{act: ACT_NOP,      cond: C_OP_EXTRACT, tgt_t: S_E0,   tgt_f: S_I0};
			S_I0:   w = '{act: ACT_INS_INIT, cond: C_FULL,       tgt_t: S_FIN,  tgt_f: S_I1};
			S_I1:   w = '{act: ACT_RD_PAR,   cond: C_POS_ROOT,   tgt_t: S_WR,   tgt_f: S_I2};
			S_I2:   w = '{act: ACT_INS_MOVE, cond: C_LESS_UP,    tgt_t: S_I1,   tgt_f: S_WR};
			S_WR:   w = '{act: ACT_WR_ENT,   cond: C_ALWAYS,     tgt_t: S_FIN,  tgt_f: S_FIN};
			S_E0:   w = '{act: ACT_EX_INIT,  cond: C_CNT_ZERO,   tgt_t: S_FIN,  tgt_f: S_E1};
			S_E1:   w = '{act: ACT_EX_ROOT,  cond: C_ALWAYS,     tgt_t: S_E2,   tgt_f: S_E2};
			S_E2:   w = '{act: ACT_EX_LAST,  cond: C_CNT_ZERO,   tgt_t: S_FIN,  tgt_f: S_E3};
			S_E3:   w = '{act: ACT_DN_LEFT,  cond: C_NO_LEFT,    tgt_t: S_WR,   tgt_f: S_E4};
			S_E4:   w = '{act: ACT_DN_CMPL,  cond: C_ALWAYS,     tgt_t: S_E5,   tgt_f: S_E5};
			S_E5:   w = '{act: ACT_DN_CMPR,  cond: C_MOVE,       tgt_t: S_E3,   tgt_f: S_WR};
			S_FIN:  w = '{act: ACT_FIN,      cond: C_OUT_FREE,   tgt_t: S_IDLE, tgt_f: S_FIN};
			default: w = '{act: ACT_NOP,     cond: C_ALWAYS,     tgt_t: S_IDLE, tgt_f: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

### hw/rtl/max_heap_priority_queue_top.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top
// binary max-heap of key/payload entries run by a microcoded sequencer
// ----------------------------------------------------------------------------
// usage:
// - input channel (in_valid/in_ready) carries opcode, new_key, new_payload;
//   opcode 0 inserts, opcode 1 extracts the entry with the largest signed key
// - output channel (out_valid/out_ready) returns one item per input item:
//   status, out_key, out_payload, fill_level
// - one item is worked on at a time; in_ready is high only while the
//   sequencer waits in its idle step
// - an inserted entry rises at most 10 levels and an extracted root's
//   replacement sinks at most 9 levels
// - an item is taken in the idle step that follows the loading of the
//   previous result; each level costs a registered memory read and a
//   compare on the way up, and two reads and two compares on the way down
// - the result sits in an output register; the next item is taken while it
//   waits, and a finished item only stalls in the last step if the earlier
//   result has not yet been taken
// - reset empties the queue at once; the entry memory is not cleared, as
//   only entries below the fill count are ever read
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic signed [31:0] new_key,
	input  logic [31:0]        new_payload,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] out_key,
	output logic [31:0]        out_payload,
	output logic [10:0]        fill_level
);

	localparam int AW = mhpq_pkg::AW;
	localparam int CW = mhpq_pkg::CW;
	localparam int LW = mhpq_pkg::LW;

	// sequencer
	mhpq_pkg::step_t  pc_q;
	mhpq_pkg::uword_t uw;
	logic             cond_hit;

	// control state
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;

	// working registers
	logic                  op_q;
	logic [31:0]           nk_q;
	logic [31:0]           np_q;
	logic [AW-1:0]         pos_q;
	logic [AW-1:0]         par_q;
	logic [AW-1:0]         best_q;
	logic                  flag_q;
	mhpq_pkg::entry_t      ent_q;
	mhpq_pkg::entry_t      bent_q;
	mhpq_pkg::status_t     st_q;
	logic [31:0]           rk_q;
	logic [31:0]           rp_q;

	// result register
	mhpq_pkg::status_t     ost_q;
	logic [31:0]           okey_q;
	logic [31:0]           opay_q;
	logic [CW-1:0]         ofill_q;

	// entry memory
	mhpq_pkg::entry_t      mem [mhpq_pkg::CAPACITY];
	mhpq_pkg::entry_t      rd_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	mhpq_pkg::entry_t      mem_wd;
	logic [AW-1:0]         mem_ra;

	// datapath terms
	logic [AW-1:0] par_n;
	logic [LW-1:0] l_idx;
	logic [LW-1:0] r_idx;
	logic          is_full;
	logic          less_up;
	logic          less_l;
	logic          take_r;
	logic          moving;
	logic          out_free;

	assign uw       = mhpq_pkg::ucode(pc_q);
	assign in_ready = (pc_q == mhpq_pkg::S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	assign par_n   = AW'((pos_q - 1'b1) >> 1);
	assign l_idx   = {pos_q, 1'b1};
	assign r_idx   = l_idx + 1'b1;
	assign is_full = (cnt_q == CW'(mhpq_pkg::CAPACITY));
	assign less_up = $signed(rd_q.key) < $signed(ent_q.key);
	assign less_l  = $signed(ent_q.key) < $signed(rd_q.key);
	// right child wins only when strictly greater than the best so far
	assign take_r  = (r_idx < LW'(cnt_q)) && ($signed(bent_q.key) < $signed(rd_q.key));
	assign moving  = take_r || flag_q;

	always_comb begin
		unique case (uw.cond)
			mhpq_pkg::C_ALWAYS:     cond_hit = 1'b1;
			mhpq_pkg::C_IN_VALID:   cond_hit = in_valid;
			mhpq_pkg::C_OP_EXTRACT: cond_hit = op_q;
			mhpq_pkg::C_FULL:       cond_hit = is_full;
			mhpq_pkg::C_POS_ROOT:   cond_hit = (pos_q == '0);
			mhpq_pkg::C_LESS_UP:    cond_hit = less_up;
			mhpq_pkg::C_CNT_ZERO:   cond_hit = (cnt_q == '0);
			mhpq_pkg::C_NO_LEFT:    cond_hit = (l_idx >= LW'(cnt_q));
			mhpq_pkg::C_MOVE:       cond_hit = moving;
			mhpq_pkg::C_OUT_FREE:   cond_hit = out_free;
			default:                cond_hit = 1'b1;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = pos_q;
		mem_wd = ent_q;
		mem_ra = '0;
		unique case (uw.act)
			mhpq_pkg::ACT_RD_PAR:   mem_ra = par_n;
			mhpq_pkg::ACT_INS_MOVE: begin
				mem_we = less_up;
				mem_wd = rd_q;
			end
			mhpq_pkg::ACT_WR_ENT:   mem_we = 1'b1;
			mhpq_pkg::ACT_EX_INIT:  mem_ra = '0;
			mhpq_pkg::ACT_EX_ROOT:  mem_ra = AW'(cnt_q - 1'b1);
			mhpq_pkg::ACT_DN_LEFT:  mem_ra = l_idx[AW-1:0];
			mhpq_pkg::ACT_DN_CMPL:  mem_ra = r_idx[AW-1:0];
			mhpq_pkg::ACT_DN_CMPR: begin
				mem_we = moving;
				mem_wd = take_r ? rd_q : bent_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	// step counter, fill count and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= mhpq_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= cond_hit ? uw.tgt_t : uw.tgt_f;
			if (uw.act == mhpq_pkg::ACT_INS_INIT && !is_full) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (uw.act == mhpq_pkg::ACT_EX_ROOT) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (uw.act == mhpq_pkg::ACT_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (uw.act)
			mhpq_pkg::ACT_IDLE: begin
				if (in_valid) begin
					op_q <= opcode;
					nk_q <= new_key;
					np_q <= new_payload;
				end
			end
			mhpq_pkg::ACT_INS_INIT: begin
				pos_q <= AW'(cnt_q);
				ent_q <= '{key: nk_q, pay: np_q};
				rk_q  <= '0;
				rp_q  <= '0;
				st_q  <= is_full ? mhpq_pkg::ST_FULL : mhpq_pkg::ST_OK;
			end
			mhpq_pkg::ACT_RD_PAR: par_q <= par_n;
			mhpq_pkg::ACT_INS_MOVE: begin
				if (less_up) begin
					pos_q <= par_q;
				end
			end
			mhpq_pkg::ACT_EX_INIT: begin
				rk_q <= '0;
				rp_q <= '0;
				st_q <= (cnt_q == '0) ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_OK;
			end
			mhpq_pkg::ACT_EX_ROOT: begin
				rk_q <= rd_q.key;
				rp_q <= rd_q.pay;
			end
			mhpq_pkg::ACT_EX_LAST: begin
				ent_q <= rd_q;
				pos_q <= '0;
			end
			mhpq_pkg::ACT_DN_CMPL: begin
				best_q <= l_idx[AW-1:0];
				flag_q <= less_l;
				bent_q <= less_l ? rd_q : ent_q;
			end
			mhpq_pkg::ACT_DN_CMPR: begin
				if (take_r) begin
					pos_q <= r_idx[AW-1:0];
				end else if (flag_q) begin
					pos_q <= best_q;
				end
			end
			mhpq_pkg::ACT_FIN: begin
				if (out_free) begin
					ost_q   <= st_q;
					okey_q  <= rk_q;
					opay_q  <= rp_q;
					ofill_q <= cnt_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = ost_q;
	assign out_key     = okey_q;
	assign out_payload = opay_q;
	assign fill_level  = mhpq_pkg::FILL_W'(ofill_q);

endmodule

### hw/rtl/mhpq_checker.sv
// ----------------------------------------------------------------------------
// mhpq_checker
// port-level checks of the heap priority queue, bound to the top level
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_top_defines.svh"

module mhpq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               opcode,
	input logic signed [31:0] new_key,
	input logic [31:0]        new_payload,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic signed [31:0] out_key,
	input logic [31:0]        out_payload,
	input logic [10:0]        fill_level
);

	// one item in flight: after an accept the input side closes
	`MHPQ_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

	// empty extract reports nothing and an empty queue
	`MHPQ_ASSERT_IMPL(a_empty_result, out_valid && status == mhpq_pkg::ST_EMPTY,
		fill_level == '0 && out_key == '0 && out_payload == '0)

	// dropped insert leaves the queue at capacity
	`MHPQ_ASSERT_IMPL(a_full_result, out_valid && status == mhpq_pkg::ST_FULL,
		fill_level == mhpq_pkg::FILL_W'(mhpq_pkg::CAPACITY) && out_key == '0 && out_payload == '0)

	// a stalled item holds
	`MHPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(out_key) && $stable(fill_level))

endmodule

bind max_heap_priority_queue_top mhpq_checker u_mhpq_checker (.*);
